// ===== rtl/mmts_pkg.sv =====
package mmts_pkg;

  localparam int MaxPointsDef = 8;
  localparam int CoordBitsDef = 16;
  localparam int FieldBits    = 16;
  localparam int LenBits      = 21;
  localparam logic [LenBits-1:0] LenMax = {LenBits{1'b1}};

  typedef struct packed {
    logic load;
    logic clear;
    logic perm_start;
    logic leg_step;
    logic tour_end;
    logic perm_next;
  } mmts_cmd_t;

  typedef struct packed {
    logic legs_done;
    logic perm_last;
    logic perm_ready;
    logic empty;
  } mmts_stat_t;

  function automatic logic [LenBits-1:0] sat_add(input logic [LenBits-1:0] a,
                                                 input logic [LenBits:0] b);
    logic [LenBits+1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > {2'b00, LenMax}) return LenMax;
    return s[LenBits-1:0];
  endfunction

endpackage

// ===== rtl/mmts_ctrl.sv =====
module mmts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_last_point,
  input  mmts_pkg::mmts_stat_t stat,
  output mmts_pkg::mmts_cmd_t  cmd,
  output logic                busy,
  output logic                out_valid
);
  import mmts_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INIT = 5'b00010,
    S_LEGS = 5'b00100,
    S_NEXT = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_last_point) state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.perm_start = 1'b1;
        state_nxt = stat.empty ? S_DONE : S_LEGS;
      end
      S_LEGS: begin
        cmd.leg_step = 1'b1;
        if (stat.legs_done) begin
          cmd.tour_end = 1'b1;
          state_nxt = stat.perm_last ? S_DONE : S_NEXT;
        end
      end
      S_NEXT: begin
        cmd.perm_next = 1'b1;
        if (stat.perm_ready) state_nxt = S_LEGS;
      end
      S_DONE: begin
        cmd.clear = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

// ===== rtl/mmts_dp.sv =====
module mmts_dp #(
  parameter int MAX_POINTS = mmts_pkg::MaxPointsDef,
  parameter int COORD_BITS = mmts_pkg::CoordBitsDef
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mmts_pkg::mmts_cmd_t                  cmd,
  input  logic signed [mmts_pkg::FieldBits-1:0] in_coord_x,
  input  logic signed [mmts_pkg::FieldBits-1:0] in_coord_y,
  input  logic signed [mmts_pkg::FieldBits-1:0] in_coord_t,
  output mmts_pkg::mmts_stat_t                 stat,
  output logic [mmts_pkg::LenBits-1:0]         out_min_tour_length,
  output logic                                 out_overflow_points
);
  import mmts_pkg::*;

  localparam int IdxBits = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CntBits = $clog2(MAX_POINTS + 1);
  localparam int CW = (COORD_BITS < FieldBits) ? COORD_BITS : FieldBits;
  localparam int DBits = CW + 1;

  typedef logic signed [CW-1:0] crd_t;

  crd_t xs_r [MAX_POINTS];
  crd_t ys_r [MAX_POINTS];
  crd_t ts_r [MAX_POINTS];
  logic [IdxBits-1:0] ord_r [MAX_POINTS];
  logic [IdxBits-1:0] ord_nxt [MAX_POINTS];
  logic [CntBits-1:0] cnt_r;
  logic               ovf_r;
  logic [LenBits-1:0] best_r, run_r;
  logic [CntBits-1:0] leg_r;
  crd_t px_r, py_r, pt_r;
  logic [1:0]         ph_r;
  logic [IdxBits-1:0] pi_r, pj_r, pl_r, ph2_r;

  crd_t qx, qy, qt;
  logic [IdxBits-1:0] cur_idx;
  logic               home;
  logic [DBits-1:0]   dx, dy, dt;
  logic [DBits+1:0]   dsum;
  logic [LenBits-1:0] run_new;
  logic [IdxBits-1:0] nm1;
  logic               full;
  logic               has_next;

  assign full = (cnt_r == CntBits'(MAX_POINTS));
  assign nm1  = IdxBits'(cnt_r - CntBits'(1));
  assign home = (leg_r == cnt_r);
  assign cur_idx = ord_r[leg_r[IdxBits-1:0]];

  always_comb begin
    if (home) begin
      qx = '0; qy = '0; qt = '0;
    end else begin
      qx = xs_r[cur_idx]; qy = ys_r[cur_idx]; qt = ts_r[cur_idx];
    end
  end

  function automatic logic [DBits-1:0] adiff(input crd_t a, input crd_t b);
    logic signed [DBits-1:0] d;
    d = DBits'(a) - DBits'(b);
    return d[DBits-1] ? DBits'(-d) : DBits'(d);
  endfunction

  assign dx = adiff(px_r, qx);
  assign dy = adiff(py_r, qy);
  assign dt = adiff(pt_r, qt);
  assign dsum = {2'b00, dx} + {2'b00, dy} + {2'b00, dt};
  assign run_new = sat_add(run_r, (LenBits + 1)'(dsum));

  // a further order exists while some neighbouring pair is still ascending
  always_comb begin
    has_next = 1'b0;
    for (int k = 1; k < MAX_POINTS; k++)
      if (k < int'(cnt_r) && ord_r[k-1] < ord_r[k]) has_next = 1'b1;
  end

  assign stat.empty = (cnt_r == '0);
  assign stat.legs_done = home;
  assign stat.perm_last = !has_next;
  assign stat.perm_ready = (ph_r == 2'd3);

  // permutation: find pivot i, then j, then swap and reverse one pair a cycle
  always_comb begin
    for (int k = 0; k < MAX_POINTS; k++) ord_nxt[k] = ord_r[k];
    if (cmd.perm_next && ph_r == 2'd1) begin
      ord_nxt[pi_r - IdxBits'(1)] = ord_r[pj_r];
      ord_nxt[pj_r] = ord_r[pi_r - IdxBits'(1)];
    end else if (cmd.perm_next && ph_r == 2'd2 && pl_r < ph2_r) begin
      ord_nxt[pl_r] = ord_r[ph2_r];
      ord_nxt[ph2_r] = ord_r[pl_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      xs_r[cnt_r[IdxBits-1:0]] <= in_coord_x[CW-1:0];
      ys_r[cnt_r[IdxBits-1:0]] <= in_coord_y[CW-1:0];
      ts_r[cnt_r[IdxBits-1:0]] <= in_coord_t[CW-1:0];
    end
    if (cmd.perm_start || cmd.tour_end || cmd.perm_next) begin
      run_r <= '0; leg_r <= '0; px_r <= '0; py_r <= '0; pt_r <= '0;
    end else if (cmd.leg_step) begin
      run_r <= run_new; leg_r <= leg_r + CntBits'(1);
      px_r <= qx; py_r <= qy; pt_r <= qt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      cnt_r <= '0; ovf_r <= 1'b0; best_r <= LenMax; ph_r <= '0;
      pi_r <= '0; pj_r <= '0; pl_r <= '0; ph2_r <= '0;
      for (int k = 0; k < MAX_POINTS; k++) ord_r[k] <= IdxBits'(k);
    end else begin
      for (int k = 0; k < MAX_POINTS; k++) ord_r[k] <= ord_nxt[k];
      if (cmd.load) begin
        if (full) ovf_r <= 1'b1;
        else cnt_r <= cnt_r + CntBits'(1);
      end
      if (cmd.tour_end && run_new < best_r) best_r <= run_new;
      if (cmd.perm_start || (cmd.tour_end && !stat.perm_last)) begin
        pi_r <= nm1; pj_r <= nm1; ph_r <= '0;
      end else if (cmd.perm_next) begin
        unique case (ph_r)
          2'd0: begin
            if (pi_r != '0 && ord_r[pi_r - IdxBits'(1)] >= ord_r[pi_r])
              pi_r <= pi_r - IdxBits'(1);
            else if (ord_r[pj_r] <= ord_r[pi_r - IdxBits'(1)])
              pj_r <= pj_r - IdxBits'(1);
            else ph_r <= 2'd1;
          end
          2'd1: begin
            ph_r <= 2'd2; pl_r <= pi_r; ph2_r <= nm1;
          end
          2'd2: begin
            if (pl_r < ph2_r) begin
              pl_r <= pl_r + IdxBits'(1); ph2_r <= ph2_r - IdxBits'(1);
            end else ph_r <= 2'd3;
          end
          default: begin
            ph_r <= '0; pi_r <= nm1; pj_r <= nm1;
          end
        endcase
      end
    end
  end

  assign out_min_tour_length = best_r;
  assign out_overflow_points = ovf_r;

endmodule

// ===== rtl/min_manhattan_tour_search.sv =====
// channel  ports                                              dir
// input    start, in_coord_x/y/t, in_last_point (busy is out)   in
// result   out_valid, out_min_tour_length, out_overflow_points out
// one point per cycle while busy is low; the marked point starts a search of n! orders,
// each walked as n + 1 legs from the origin and back, then stepped to the next order,
// with a start state first and a result state last; busy stays high throughout
// synchronous active-low reset; no stall on the result side
module min_manhattan_tour_search #(
  parameter int MAX_POINTS = mmts_pkg::MaxPointsDef,
  parameter int COORD_BITS = mmts_pkg::CoordBitsDef
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [mmts_pkg::FieldBits-1:0] in_coord_x,
  input  logic signed [mmts_pkg::FieldBits-1:0] in_coord_y,
  input  logic signed [mmts_pkg::FieldBits-1:0] in_coord_t,
  input  logic                                  in_last_point,
  output logic                                  out_valid,
  output logic [mmts_pkg::LenBits-1:0]          out_min_tour_length,
  output logic                                  out_overflow_points
);
  import mmts_pkg::*;

  mmts_cmd_t  cmd;
  mmts_stat_t stat;

  mmts_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_last_point, .stat, .cmd, .busy, .out_valid
  );

  mmts_dp #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk, .rst_n, .cmd, .in_coord_x, .in_coord_y, .in_coord_t, .stat,
    .out_min_tour_length, .out_overflow_points
  );

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("strobe longer than one cycle");
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last_point) |=> busy) else $error("search not started");

endmodule

// ===== tb/mmts_checker.sv =====
module mmts_checker #(
  parameter int MAX_POINTS = mmts_pkg::MaxPointsDef
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic signed [mmts_pkg::FieldBits-1:0] in_coord_x,
  input  logic signed [mmts_pkg::FieldBits-1:0] in_coord_y,
  input  logic signed [mmts_pkg::FieldBits-1:0] in_coord_t,
  input  logic                                  in_last_point,
  input  logic                                  out_valid,
  input  logic [mmts_pkg::LenBits-1:0]          out_min_tour_length,
  input  logic                                  out_overflow_points,
  output int                                    fail_count,
  output int                                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [mmts_pkg::LenBits-1:0] tour_len;
    logic                         overflow;
  } tour_result_t;

  int           pts_x [MAX_POINTS];
  int           pts_y [MAX_POINTS];
  int           pts_t [MAX_POINTS];
  int           n_points;
  logic         dropped;
  tour_result_t tour_q[$];

  function automatic int leg_len(int ax, int ay, int at, int bx, int by, int bt);
    int dx, dy, dt;
    dx = ax - bx;
    dy = ay - by;
    dt = at - bt;
    return (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy) + (dt < 0 ? -dt : dt);
  endfunction

  function automatic int sat_len(int a, int b);
    int s;
    s = a + b;
    return (s > int'(mmts_pkg::LenMax)) ? int'(mmts_pkg::LenMax) : s;
  endfunction

  function automatic int shortest_tour(int n);
    int ord [MAX_POINTS];
    int best, run, i, j, tmp;
    bit more;
    best = int'(mmts_pkg::LenMax);
    for (i = 0; i < MAX_POINTS; i++) ord[i] = i;
    if (n == 0) return best;
    more = 1;
    while (more) begin
      run = leg_len(0, 0, 0, pts_x[ord[0]], pts_y[ord[0]], pts_t[ord[0]]);
      for (i = 0; i + 1 < n; i++)
        run = sat_len(run, leg_len(pts_x[ord[i]], pts_y[ord[i]], pts_t[ord[i]],
                                   pts_x[ord[i+1]], pts_y[ord[i+1]], pts_t[ord[i+1]]));
      run = sat_len(run, leg_len(pts_x[ord[n-1]], pts_y[ord[n-1]], pts_t[ord[n-1]],
                                 0, 0, 0));
      if (run < best) best = run;
      // next lexicographic order
      i = n - 1;
      while (i > 0 && ord[i-1] >= ord[i]) i--;
      if (i == 0) begin
        more = 0;
      end else begin
        j = n - 1;
        while (ord[j] <= ord[i-1]) j--;
        tmp = ord[i-1]; ord[i-1] = ord[j]; ord[j] = tmp;
        for (j = n - 1; i < j; i++, j--) begin
          tmp = ord[i]; ord[i] = ord[j]; ord[j] = tmp;
        end
      end
    end
    return best;
  endfunction

  always @(posedge clk) begin
    tour_result_t exp_r;
    if (!rst_n) begin
      n_points   = 0;
      dropped    = 0;
      fail_count <= 0;
      tour_q.delete();
    end else begin
      if (out_valid) begin
        if (tour_q.size() == 0) begin
          $display("%0t: unexpected result len=%0d ovf=%0b", $time,
                   out_min_tour_length, out_overflow_points);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = tour_q.pop_front();
          if (out_min_tour_length !== exp_r.tour_len ||
              out_overflow_points !== exp_r.overflow) begin
            $display("%0t: mismatch expected len=%0d ovf=%0b actual len=%0d ovf=%0b",
                     $time, exp_r.tour_len, exp_r.overflow,
                     out_min_tour_length, out_overflow_points);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        if (n_points < MAX_POINTS) begin
          pts_x[n_points] = int'(in_coord_x);
          pts_y[n_points] = int'(in_coord_y);
          pts_t[n_points] = int'(in_coord_t);
          n_points = n_points + 1;
        end else begin
          dropped = 1;
        end
        if (in_last_point) begin
          exp_r.tour_len = mmts_pkg::LenBits'(shortest_tour(n_points));
          exp_r.overflow = dropped;
          tour_q.push_back(exp_r);
          n_points = 0;
          dropped  = 0;
        end
      end
    end
    pending = tour_q.size();
  end
endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic                                  clk;
  logic                                  rst_n;
  logic                                  start;
  logic                                  busy;
  logic signed [mmts_pkg::FieldBits-1:0] in_coord_x;
  logic signed [mmts_pkg::FieldBits-1:0] in_coord_y;
  logic signed [mmts_pkg::FieldBits-1:0] in_coord_t;
  logic                                  in_last_point;
  logic                                  out_valid;
  logic [mmts_pkg::LenBits-1:0]          out_min_tour_length;
  logic                                  out_overflow_points;
  int                                    fail_count;
  int                                    pending;
  int                                    n_items;

  min_manhattan_tour_search u_top (.*);

  mmts_checker u_chk (.*);

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  task automatic send_point(int x, int y, int t, bit last_pt);
    repeat ($urandom_range(0, 5)) @(negedge clk);
    while (busy) @(negedge clk);
    start         = 1'b1;
    in_coord_x    = 16'(x);
    in_coord_y    = 16'(y);
    in_coord_t    = 16'(t);
    in_last_point = last_pt;
    @(negedge clk);
    start         = 1'b0;
    in_last_point = 1'($urandom_range(0, 1));
    n_items++;
  endtask

  task automatic send_random_set(int n);
    for (int i = 0; i < n; i++)
      send_point($urandom, $urandom, $urandom, i == n - 1);
  endtask

  initial begin
    #60_000_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    int sz;
    n_items       = 0;
    start         = 1'b0;
    in_coord_x    = '0;
    in_coord_y    = '0;
    in_coord_t    = '0;
    in_last_point = 1'b0;
    rst_n         = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // single point at the origin, single extreme points, then a set of three points
    send_point(0, 0, 0, 1);
    send_point(32767, -32768, 32767, 1);
    send_point(-32768, 32767, -32768, 1);
    send_point(-1, 1, -1, 0);
    send_point(100, -200, 300, 0);
    send_point(-32768, -32768, -32768, 1);
    // full store of eight points, mostly extremes, one extra dropped, marked extra also dropped
    send_point(32767, 32767, 32767, 0);
    send_point(-32768, -32768, -32768, 0);
    send_point(32767, -32768, 0, 0);
    send_point(-32768, 32767, 0, 0);
    send_point(0, 32767, -32768, 0);
    send_point(0, -32768, 32767, 0);
    send_point(12345, -23456, 1, 0);
    send_point(-5, 7, 32000, 0);
    send_point(1, 1, 1, 0);
    send_point(-1, -1, -1, 1);

    while (n_items < 100) begin
      sz = ($urandom_range(0, 15) == 0) ? 6 : $urandom_range(1, 5);
      send_random_set(sz);
    end

    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
